// ===== rtl/gtd_pkg.sv =====
// Shared types and constants for the grid trigger divider.
package gtd_pkg;

    // Grid geometry and field widths.
    localparam int GRID_SIDE = 4;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int LANE_W    = 2;
    localparam int CELL_W    = 2 * LANE_W;
    localparam int REQ_W     = 3;

    // Cell fields and their limits.
    localparam int MAX_DIVISION = 64;
    localparam int DIV_W        = 7;
    localparam int SHIFT_W      = 8;
    localparam int PROB_BITS    = 8;
    localparam int PROB_W       = PROB_BITS + 1;
    localparam int PROB_FULL    = 1 << PROB_BITS;

    // Beat counter, target and remainder unit sizes.
    localparam int COUNT_W    = 32;
    localparam int TARGET_W   = COUNT_W + 2;
    localparam int MAG_W      = COUNT_W + 1;
    localparam int RADIX_BITS = 8;
    localparam int DIV_STEPS  = (MAG_W + RADIX_BITS - 1) / RADIX_BITS;
    localparam int DIVIDEND_W = DIV_STEPS * RADIX_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Random generator.
    localparam logic [COUNT_W-1:0] LFSR_TAPS = 32'h8020_0003;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_BEAT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_COLUMN = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ROW    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              accept;
        logic              load;
        logic              step;
        logic              test;
        logic              finish;
        logic [CELL_W-1:0] cell_idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
    } t_status;

endpackage

// ===== rtl/gtd_controller.sv =====
// Sequencer that walks the grid cells for a beat request.
module gtd_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gtd_pkg::REQ_W-1:0]  i_req_type,
    input  gtd_pkg::t_status           i_status,
    output gtd_pkg::t_cmd              o_cmd,
    output logic                       o_busy
);
    import gtd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOAD   = 5'b00010,
        S_DIV    = 5'b00100,
        S_TEST   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);

    t_state              r_state, n_state;
    logic [CELL_W-1:0]   r_cell, n_cell;
    logic [STEP_W-1:0]   r_step, n_step;

    // Next state and command decode.
    always_comb begin
        n_state        = r_state;
        n_cell         = r_cell;
        n_step         = r_step;
        o_cmd          = '0;
        o_cmd.cell_idx = r_cell;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_req_type == REQ_BEAT) begin
                        n_state = S_LOAD;
                        n_cell  = '0;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                // A skipped cell needs no remainder.
                if (i_status.skip) begin
                    n_state = S_TEST;
                end else begin
                    o_cmd.step = 1'b1;
                    if (r_step == LAST_STEP) begin
                        n_state = S_TEST;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                if (r_cell == LAST_CELL) begin
                    n_state = S_FINISH;
                end else begin
                    n_cell  = r_cell + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cell  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_cell  <= n_cell;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/gtd_datapath.sv =====
// Cell tables, beat counter, remainder unit, random draw and result registers.
module gtd_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gtd_pkg::t_cmd                      i_cmd,
    output gtd_pkg::t_status                   o_status,
    input  logic [gtd_pkg::REQ_W-1:0]          i_req_type,
    input  logic [gtd_pkg::CELL_W-1:0]         i_cell_index,
    input  logic [gtd_pkg::LANE_W-1:0]         i_lane_index,
    input  logic [gtd_pkg::DIV_W-1:0]          i_cell_division,
    input  logic signed [gtd_pkg::SHIFT_W-1:0] i_cell_shift,
    input  logic [gtd_pkg::PROB_W-1:0]         i_cell_probability,
    input  logic                               i_seed_we,
    input  logic [gtd_pkg::COUNT_W-1:0]        i_seed_wdata,
    output logic                               o_done,
    output logic [gtd_pkg::GRID_SIDE-1:0]      o_column_triggers,
    output logic [gtd_pkg::GRID_SIDE-1:0]      o_row_triggers,
    output logic [gtd_pkg::GRID_SIDE-1:0]      o_column_enables,
    output logic [gtd_pkg::GRID_SIDE-1:0]      o_row_enables,
    output logic [gtd_pkg::COUNT_W-1:0]        o_beat_count
);
    import gtd_pkg::*;

    localparam logic [DIV_W-1:0]          DIV_MAX   = DIV_W'(MAX_DIVISION);
    localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(MAX_DIVISION);
    localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = SHIFT_W'(-MAX_DIVISION);
    localparam logic [PROB_W-1:0]         PROB_MAX  = PROB_W'(PROB_FULL);
    localparam logic [GRID_SIDE-1:0]      LANE_ONE  = GRID_SIDE'(1);

    // One Galois step of the random generator.
    function automatic logic [COUNT_W-1:0] lfsr_advance(input logic [COUNT_W-1:0] x);
        logic [COUNT_W-1:0] y;
        y = x >> 1;
        if (x[0]) begin
            y = y ^ LFSR_TAPS;
        end
        return y;
    endfunction

    // Eight restoring remainder steps on one dividend byte.
    function automatic logic [DIV_W-1:0] mod_step(
        input logic [DIV_W-1:0]      rem,
        input logic [RADIX_BITS-1:0] bits,
        input logic [DIV_W-1:0]      d
    );
        logic [DIV_W:0]   t;
        logic [DIV_W-1:0] r;
        r = rem;
        for (int k = RADIX_BITS - 1; k >= 0; k--) begin
            t = {r, bits[k]};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
            end
            r = t[DIV_W-1:0];
        end
        return r;
    endfunction

    // Cell tables.
    logic [DIV_W-1:0]          r_div_tab   [CELLS];
    logic signed [SHIFT_W-1:0] r_shift_tab [CELLS];
    logic [PROB_W-1:0]         r_prob_tab  [CELLS];

    // Architectural state.
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [GRID_SIDE-1:0] r_col_mask, n_col_mask;
    logic [GRID_SIDE-1:0] r_row_mask, n_row_mask;
    logic [COUNT_W-1:0]   r_lfsr, n_lfsr;

    // Per-cell working registers.
    logic [DIVIDEND_W-1:0] r_dividend;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_div;
    logic [PROB_W-1:0]     r_prob;
    logic                  r_skip;
    logic [GRID_SIDE-1:0]  r_col_fire;
    logic [GRID_SIDE-1:0]  r_row_fire;

    // Result registers.
    logic                 r_done;
    logic [GRID_SIDE-1:0] r_col_trig;
    logic [GRID_SIDE-1:0] r_row_trig;
    logic [GRID_SIDE-1:0] r_col_en;
    logic [GRID_SIDE-1:0] r_row_en;
    logic [COUNT_W-1:0]   r_count_out;

    logic signed [TARGET_W-1:0] w_target;
    logic [DIV_W-1:0]           w_div_sat;
    logic signed [SHIFT_W-1:0]  w_shift_sat;
    logic [PROB_W-1:0]          w_prob_sat;
    logic [COUNT_W-1:0]         w_lfsr_adv;
    logic                       w_draw;
    logic                       w_hit;
    logic                       w_beat;

    assign w_beat = (i_req_type == REQ_BEAT);

    // Exact target of the current cell: counter plus its shift.
    assign w_target = $signed({2'b00, r_count})
                    + $signed({{(TARGET_W - SHIFT_W){r_shift_tab[i_cmd.cell_idx][SHIFT_W-1]}},
                               r_shift_tab[i_cmd.cell_idx]});

    // Saturation of written cell fields.
    assign w_div_sat   = (i_cell_division > DIV_MAX) ? DIV_MAX : i_cell_division;
    assign w_shift_sat = (i_cell_shift > SHIFT_MAX) ? SHIFT_MAX :
                         (i_cell_shift < SHIFT_MIN) ? SHIFT_MIN : i_cell_shift;
    assign w_prob_sat  = (i_cell_probability > PROB_MAX) ? PROB_MAX : i_cell_probability;

    // A qualifying cell draws one random value.
    assign w_lfsr_adv = lfsr_advance(r_lfsr);
    assign w_draw     = i_cmd.test && !r_skip && (r_rem == '0);
    assign w_hit      = ({1'b0, w_lfsr_adv[PROB_BITS-1:0]} < r_prob);

    // Next values of counter, enable masks and random generator.
    always_comb begin
        n_count    = r_count;
        n_col_mask = r_col_mask;
        n_row_mask = r_row_mask;
        if (i_cmd.accept) begin
            unique case (i_req_type)
                REQ_BEAT:   n_count    = r_count + 1'b1;
                REQ_CLEAR:  n_count    = '0;
                REQ_COLUMN: n_col_mask = r_col_mask ^ (LANE_ONE << i_lane_index);
                REQ_ROW:    n_row_mask = r_row_mask ^ (LANE_ONE << i_lane_index);
                default:    n_count    = r_count;
            endcase
        end
        n_lfsr = r_lfsr;
        if (i_seed_we) begin
            n_lfsr = (i_seed_wdata != '0) ? i_seed_wdata : COUNT_W'(1);
        end else if (w_draw) begin
            n_lfsr = w_lfsr_adv;
        end
    end

    // Control-bearing state and the cell tables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_col_mask <= '1;
            r_row_mask <= '1;
            r_lfsr     <= COUNT_W'(1);
            r_done     <= 1'b0;
            for (int k = 0; k < CELLS; k++) begin
                r_div_tab[k]   <= '0;
                r_shift_tab[k] <= '0;
                r_prob_tab[k]  <= PROB_MAX;
            end
        end else begin
            r_count    <= n_count;
            r_col_mask <= n_col_mask;
            r_row_mask <= n_row_mask;
            r_lfsr     <= n_lfsr;
            r_done     <= (i_cmd.accept && !w_beat) || i_cmd.finish;
            if (i_cmd.accept && (i_req_type == REQ_WRITE)) begin
                r_div_tab[i_cell_index]   <= w_div_sat;
                r_shift_tab[i_cell_index] <= w_shift_sat;
                r_prob_tab[i_cell_index]  <= w_prob_sat;
            end
        end
    end

    // Per-cell walk: load, remainder steps and trigger collection.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_beat) begin
            r_col_fire <= '0;
            r_row_fire <= '0;
        end else if (w_draw && w_hit) begin
            r_col_fire <= r_col_fire | (LANE_ONE << i_cmd.cell_idx[LANE_W-1:0]);
            r_row_fire <= r_row_fire | (LANE_ONE << i_cmd.cell_idx[CELL_W-1:LANE_W]);
        end
        if (i_cmd.load) begin
            r_dividend <= {{(DIVIDEND_W - MAG_W){1'b0}}, w_target[MAG_W-1:0]};
            r_rem      <= '0;
            r_div      <= r_div_tab[i_cmd.cell_idx];
            r_prob     <= r_prob_tab[i_cmd.cell_idx];
            r_skip     <= (r_div_tab[i_cmd.cell_idx] == '0) || w_target[TARGET_W-1];
        end else if (i_cmd.step) begin
            r_rem      <= mod_step(r_rem, r_dividend[DIVIDEND_W-1 -: RADIX_BITS], r_div);
            r_dividend <= r_dividend << RADIX_BITS;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !w_beat) begin
            r_col_trig  <= '0;
            r_row_trig  <= '0;
            r_col_en    <= n_col_mask;
            r_row_en    <= n_row_mask;
            r_count_out <= n_count;
        end else if (i_cmd.finish) begin
            r_col_trig  <= r_col_fire & r_col_mask;
            r_row_trig  <= r_row_fire & r_row_mask;
            r_col_en    <= r_col_mask;
            r_row_en    <= r_row_mask;
            r_count_out <= r_count;
        end
    end

    assign o_status.skip     = r_skip;
    assign o_done            = r_done;
    assign o_column_triggers = r_col_trig;
    assign o_row_triggers    = r_row_trig;
    assign o_column_enables  = r_col_en;
    assign o_row_enables     = r_row_en;
    assign o_beat_count      = r_count_out;

endmodule

// ===== rtl/grid_trigger_divider_top.sv =====
// Top level of the grid trigger divider: controller, datapath and checks.
// Non-beat requests: result transfer in the cycle after the accept, one request a cycle.
// Beat requests: each cell passes through load, five remainder steps and the draw,
// or load, the division state without a step and the draw when skipped; the result transfers after the walk,
// and the next request can be taken in the cycle it is shown; the shared remainder unit serialises the walk.
// Synchronous active-low reset restores all cell tables, masks, counter and seed.
module grid_trigger_divider_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [gtd_pkg::REQ_W-1:0]          i_req_type,
    input  logic [gtd_pkg::CELL_W-1:0]         i_cell_index,
    input  logic [gtd_pkg::LANE_W-1:0]         i_lane_index,
    input  logic [gtd_pkg::DIV_W-1:0]          i_cell_division,
    input  logic signed [gtd_pkg::SHIFT_W-1:0] i_cell_shift,
    input  logic [gtd_pkg::PROB_W-1:0]         i_cell_probability,
    input  logic                               i_seed_we,
    input  logic [gtd_pkg::COUNT_W-1:0]        i_seed_wdata,
    output logic                               o_done,
    output logic [gtd_pkg::GRID_SIDE-1:0]      o_column_triggers,
    output logic [gtd_pkg::GRID_SIDE-1:0]      o_row_triggers,
    output logic [gtd_pkg::GRID_SIDE-1:0]      o_column_enables,
    output logic [gtd_pkg::GRID_SIDE-1:0]      o_row_enables,
    output logic [gtd_pkg::COUNT_W-1:0]        o_beat_count
);
    import gtd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer.
    gtd_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (o_busy)
    );

    // Datapath.
    gtd_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_req_type         (i_req_type),
        .i_cell_index       (i_cell_index),
        .i_lane_index       (i_lane_index),
        .i_cell_division    (i_cell_division),
        .i_cell_shift       (i_cell_shift),
        .i_cell_probability (i_cell_probability),
        .i_seed_we          (i_seed_we),
        .i_seed_wdata       (i_seed_wdata),
        .o_done             (o_done),
        .o_column_triggers  (o_column_triggers),
        .o_row_triggers     (o_row_triggers),
        .o_column_enables   (o_column_enables),
        .o_row_enables      (o_row_enables),
        .o_beat_count       (o_beat_count)
    );

`ifndef ASSERT_OFF
    // A result transfer never overlaps a busy walk.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && o_busy))
        else $error("result strobe while busy");

    // An accepted beat starts the cell walk.
    a_beat_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req_type == REQ_BEAT)) |=> (o_busy && !o_done))
        else $error("beat request did not start the walk");

    // Any other request answers in the next cycle.
    a_other_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_req_type != REQ_BEAT)) |=> (o_done && !o_busy))
        else $error("non-beat request did not answer at once");

    // Reported triggers are always within the enable masks.
    a_trig_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (((o_column_triggers & ~o_column_enables) == '0)
                 && ((o_row_triggers & ~o_row_enables) == '0)))
        else $error("trigger outside enable mask");
`endif

endmodule

// ===== tb/sv/tb_grid_trigger_divider_top.sv =====
// Self-checking testbench for the grid trigger divider: directed table, random phases, predictor.
module tb_grid_trigger_divider_top;
    import gtd_pkg::*;

    // Request codes that the block must treat as no-ops.
    localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    localparam int PHASES     = 5;
    localparam int PHASE_REQS = 250;
    localparam int DRAIN_WAIT = 150;

    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic [CELL_W-1:0]         cell_idx;
        logic [LANE_W-1:0]         lane;
        logic [DIV_W-1:0]          division;
        logic signed [SHIFT_W-1:0] shift;
        logic [PROB_W-1:0]         probability;
    } t_grid_request;

    typedef struct {
        logic [GRID_SIDE-1:0] col_fire;
        logic [GRID_SIDE-1:0] row_fire;
        logic [GRID_SIDE-1:0] col_en;
        logic [GRID_SIDE-1:0] row_en;
        logic [COUNT_W-1:0]   count;
    } t_grid_outcome;

    typedef struct {
        t_grid_request rq;
        bit            typed;
        t_grid_outcome want;
    } t_stim_row;

    // Block ports.
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic                      o_busy;
    logic [REQ_W-1:0]          i_req_type = '0;
    logic [CELL_W-1:0]         i_cell_index = '0;
    logic [LANE_W-1:0]         i_lane_index = '0;
    logic [DIV_W-1:0]          i_cell_division = '0;
    logic signed [SHIFT_W-1:0] i_cell_shift = '0;
    logic [PROB_W-1:0]         i_cell_probability = '0;
    logic                      i_seed_we = 1'b0;
    logic [COUNT_W-1:0]        i_seed_wdata = '0;
    logic                      o_done;
    logic [GRID_SIDE-1:0]      o_column_triggers;
    logic [GRID_SIDE-1:0]      o_row_triggers;
    logic [GRID_SIDE-1:0]      o_column_enables;
    logic [GRID_SIDE-1:0]      o_row_enables;
    logic [COUNT_W-1:0]        o_beat_count;

    // Predictor state of the grid.
    logic [DIV_W-1:0]   cell_div  [CELLS];
    int                 cell_offs [CELLS];
    logic [PROB_W-1:0]  cell_prob [CELLS];
    logic [COUNT_W-1:0] beat_total;
    logic [GRID_SIDE-1:0] col_mask;
    logic [GRID_SIDE-1:0] row_mask;
    logic [COUNT_W-1:0] lfsr_state;

    t_grid_outcome pending_outcomes[$];
    t_stim_row     directed_rows[$];

    int mismatch_count = 0;
    int results_checked = 0;
    int fired_results = 0;
    int beats_sent = 0;
    int writes_sent = 0;
    int reqs_sent = 0;
    int seeds_loaded = 0;

    grid_trigger_divider_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_req_type         (i_req_type),
        .i_cell_index       (i_cell_index),
        .i_lane_index       (i_lane_index),
        .i_cell_division    (i_cell_division),
        .i_cell_shift       (i_cell_shift),
        .i_cell_probability (i_cell_probability),
        .i_seed_we          (i_seed_we),
        .i_seed_wdata       (i_seed_wdata),
        .o_done             (o_done),
        .o_column_triggers  (o_column_triggers),
        .o_row_triggers     (o_row_triggers),
        .o_column_enables   (o_column_enables),
        .o_row_enables      (o_row_enables),
        .o_beat_count       (o_beat_count)
    );

    // Clock generation.
    always #5 i_clk = ~i_clk;

    // Applies one request to the predicted grid and returns the result it should give.
    function automatic t_grid_outcome next_grid_outcome(t_grid_request rq);
        t_grid_outcome res;
        longint        tgt;
        int            offs;
        logic          lsb;
        res.col_fire = '0;
        res.row_fire = '0;
        case (rq.kind)
            REQ_BEAT: begin
                beat_total = beat_total + 1;
                for (int i = 0; i < CELLS; i++) begin
                    if (cell_div[i] != 0) begin
                        tgt = longint'(beat_total) + longint'(cell_offs[i]);
                        if (tgt >= 0 && (tgt % longint'(cell_div[i])) == 0) begin
                            // Galois step, then the low byte is the draw.
                            lsb = lfsr_state[0];
                            lfsr_state = lfsr_state >> 1;
                            if (lsb) begin
                                lfsr_state = lfsr_state ^ LFSR_TAPS;
                            end
                            if ({1'b0, lfsr_state[PROB_BITS-1:0]} < cell_prob[i]) begin
                                res.col_fire[i % GRID_SIDE] = 1'b1;
                                res.row_fire[i / GRID_SIDE] = 1'b1;
                            end
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                beat_total = '0;
            end
            REQ_COLUMN: begin
                col_mask[rq.lane] = ~col_mask[rq.lane];
            end
            REQ_ROW: begin
                row_mask[rq.lane] = ~row_mask[rq.lane];
            end
            REQ_WRITE: begin
                // Division, shift and probability saturate on write.
                offs = int'(rq.shift);
                if (offs > MAX_DIVISION) offs = MAX_DIVISION;
                if (offs < -MAX_DIVISION) offs = -MAX_DIVISION;
                cell_offs[rq.cell_idx] = offs;
                cell_div[rq.cell_idx] = (rq.division > MAX_DIVISION) ? DIV_W'(MAX_DIVISION)
                                                                     : rq.division;
                cell_prob[rq.cell_idx] = (rq.probability > PROB_FULL) ? PROB_W'(PROB_FULL)
                                                                      : rq.probability;
            end
            default: begin
            end
        endcase
        res.col_fire = res.col_fire & col_mask;
        res.row_fire = res.row_fire & row_mask;
        res.col_en = col_mask;
        res.row_en = row_mask;
        res.count = beat_total;
        return res;
    endfunction

    // Adds one line to the directed table.
    task automatic add_row(input logic [REQ_W-1:0] kind, input int cell_no, input int lane,
                           input int div, input int shift, input int prob, input bit typed,
                           input int cf, input int rf, input int ce, input int re,
                           input logic [COUNT_W-1:0] cnt);
        t_stim_row r;
        r.rq.kind = kind;
        r.rq.cell_idx = CELL_W'(cell_no);
        r.rq.lane = LANE_W'(lane);
        r.rq.division = DIV_W'(div);
        r.rq.shift = SHIFT_W'(shift);
        r.rq.probability = PROB_W'(prob);
        r.typed = typed;
        r.want.col_fire = GRID_SIDE'(cf);
        r.want.row_fire = GRID_SIDE'(rf);
        r.want.col_en = GRID_SIDE'(ce);
        r.want.row_en = GRID_SIDE'(re);
        r.want.count = cnt;
        directed_rows.push_back(r);
    endtask

    // Drives one request, waits for its transfer and records the expected result.
    task automatic send_request(input t_grid_request rq, input bit typed,
                                input t_grid_outcome want);
        t_grid_outcome pred;
        i_start <= 1'b1;
        i_req_type <= rq.kind;
        i_cell_index <= rq.cell_idx;
        i_lane_index <= rq.lane;
        i_cell_division <= rq.division;
        i_cell_shift <= rq.shift;
        i_cell_probability <= rq.probability;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        pred = next_grid_outcome(rq);
        if (typed) begin
            pending_outcomes.push_back(want);
        end else begin
            pending_outcomes.push_back(pred);
        end
        reqs_sent++;
        if (rq.kind == REQ_BEAT) beats_sent++;
        if (rq.kind == REQ_WRITE) writes_sent++;
    endtask

    // Inserts an idle burst on the request side now and then.
    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 5) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Loads the seed register once the block has drained.
    task automatic load_seed_register(input logic [COUNT_W-1:0] value);
        i_start <= 1'b0;
        while (pending_outcomes.size() != 0 || o_busy !== 1'b0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_seed_we <= 1'b1;
        i_seed_wdata <= value;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
        i_seed_wdata <= $urandom;
        lfsr_state = (value != 0) ? value : 32'd1;
        seeds_loaded++;
    endtask

    // Builds a random request, mostly beats and cell writes with useful content.
    function automatic t_grid_request random_request();
        t_grid_request rq;
        int            pick;
        rq.cell_idx = CELL_W'($urandom);
        rq.lane = LANE_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) rq.division = '0;
        else if (pick < 80) rq.division = DIV_W'($urandom_range(1, 8));
        else if (pick < 92) rq.division = DIV_W'($urandom_range(9, MAX_DIVISION));
        else rq.division = DIV_W'($urandom_range(MAX_DIVISION + 1, 127));
        pick = $urandom_range(0, 99);
        if (pick < 70) rq.shift = SHIFT_W'(int'($urandom_range(0, 16)) - 8);
        else rq.shift = SHIFT_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25) rq.probability = PROB_W'(PROB_FULL);
        else if (pick < 40) rq.probability = PROB_W'($urandom_range(PROB_FULL + 1, 511));
        else rq.probability = PROB_W'($urandom_range(0, PROB_FULL - 1));
        pick = $urandom_range(0, 99);
        if (pick < 50) rq.kind = REQ_BEAT;
        else if (pick < 72) rq.kind = REQ_WRITE;
        else if (pick < 80) rq.kind = REQ_COLUMN;
        else if (pick < 88) rq.kind = REQ_ROW;
        else if (pick < 95) rq.kind = REQ_CLEAR;
        else begin
            case ($urandom_range(0, 2))
                0: rq.kind = REQ_SPARE_5;
                1: rq.kind = REQ_SPARE_6;
                default: rq.kind = REQ_SPARE_7;
            endcase
        end
        return rq;
    endfunction

    // Result checker: every strobe is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_grid_outcome want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with no expectation waiting");
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (o_column_triggers !== 0 || o_row_triggers !== 0) fired_results++;
                if (o_column_triggers !== want.col_fire) begin
                    $error("column_triggers expected %0h actual %0h",
                           want.col_fire, o_column_triggers);
                    mismatch_count++;
                end
                if (o_row_triggers !== want.row_fire) begin
                    $error("row_triggers expected %0h actual %0h",
                           want.row_fire, o_row_triggers);
                    mismatch_count++;
                end
                if (o_column_enables !== want.col_en) begin
                    $error("column_enables expected %0h actual %0h",
                           want.col_en, o_column_enables);
                    mismatch_count++;
                end
                if (o_row_enables !== want.row_en) begin
                    $error("row_enables expected %0h actual %0h",
                           want.row_en, o_row_enables);
                    mismatch_count++;
                end
                if (o_beat_count !== want.count) begin
                    $error("beat_count expected %0h actual %0h", want.count, o_beat_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        t_grid_outcome no_want;
        t_grid_request rq;
        logic [COUNT_W-1:0] seed_plan [PHASES];
        no_want = '{default: '0};

        // Predicted state after reset.
        for (int i = 0; i < CELLS; i++) begin
            cell_div[i] = '0;
            cell_offs[i] = 0;
            cell_prob[i] = PROB_W'(PROB_FULL);
        end
        beat_total = '0;
        col_mask = '1;
        row_mask = '1;
        lfsr_state = 32'd1;

        // Directed table: typed results where they are obvious.
        add_row(REQ_BEAT, 0, 0, 0, 0, 0, 1, 0, 0, 'hF, 'hF, 1);
        add_row(REQ_CLEAR, 9, 3, 127, -1, 511, 1, 0, 0, 'hF, 'hF, 0);
        add_row(REQ_COLUMN, 0, 0, 0, 0, 0, 1, 0, 0, 'hE, 'hF, 0);
        add_row(REQ_COLUMN, 0, 0, 0, 0, 0, 1, 0, 0, 'hF, 'hF, 0);
        add_row(REQ_ROW, 0, 3, 0, 0, 0, 1, 0, 0, 'hF, 'h7, 0);
        add_row(REQ_ROW, 0, 3, 0, 0, 0, 1, 0, 0, 'hF, 'hF, 0);
        add_row(REQ_SPARE_5, 1, 1, 1, 1, 1, 1, 0, 0, 'hF, 'hF, 0);
        add_row(REQ_SPARE_6, 0, 0, 0, 0, 0, 1, 0, 0, 'hF, 'hF, 0);
        add_row(REQ_SPARE_7, 15, 3, 127, -1, 511, 1, 0, 0, 'hF, 'hF, 0);
        add_row(REQ_WRITE, 0, 0, 1, 0, 256, 1, 0, 0, 'hF, 'hF, 0);
        add_row(REQ_BEAT, 0, 0, 0, 0, 0, 1, 1, 1, 'hF, 'hF, 1);
        // Saturation of all three cell fields at their upper ends, and of the shift at its lower end.
        add_row(REQ_WRITE, 15, 0, 127, 127, 511, 1, 0, 0, 'hF, 'hF, 1);
        add_row(REQ_WRITE, 5, 0, 64, -128, 0, 1, 0, 0, 'hF, 'hF, 1);
        add_row(REQ_WRITE, 10, 0, 2, -1, 128, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BEAT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BEAT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 'hF, 'hF, 0);
        // Negative shift keeps the target below zero for the first beats.
        add_row(REQ_WRITE, 3, 0, 3, -64, 255, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BEAT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_COLUMN, 0, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_ROW, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BEAT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BEAT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(REQ_WRITE, 0, 0, 0, 64, 256, 0, 0, 0, 0, 0, 0);
        add_row(REQ_BEAT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // Synchronous reset, held and then released.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            maybe_idle(1'b1);
            send_request(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].want);
        end

        // Random phases, each under its own seed; the all-ones and zero seeds come first.
        seed_plan[0] = 32'hFFFF_FFFF;
        seed_plan[1] = 32'h0;
        seed_plan[2] = $urandom | 32'd1;
        seed_plan[3] = 32'h1;
        seed_plan[4] = $urandom | 32'h8000_0000;
        for (int p = 0; p < PHASES; p++) begin
            load_seed_register(seed_plan[p]);
            for (int n = 0; n < PHASE_REQS; n++) begin
                maybe_idle(p != PHASES - 1);
                rq = random_request();
                send_request(rq, 1'b0, no_want);
            end
        end
        i_start <= 1'b0;

        // Drain outstanding results, then allow time for one full beat walk.
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d requests (%0d beats, %0d cell writes) under %0d seed settings.",
                 reqs_sent, beats_sent, writes_sent, seeds_loaded);
        $display("Checked %0d results, %0d of them with triggers, %0d mismatches.",
                 results_checked, fired_results, mismatch_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== grid_trigger_divider_top.f =====
rtl/gtd_pkg.sv
rtl/gtd_controller.sv
rtl/gtd_datapath.sv
rtl/grid_trigger_divider_top.sv
tb/sv/tb_grid_trigger_divider_top.sv
